// ===== rtl/bez_pkg.sv =====
// bezier easing package: shared widths and types
// no dependencies
package bez_pkg;
  localparam int FRAC_BITS = 16;
  localparam int CODE_W = 7;
  localparam int POS_W  = FRAC_BITS + 1;
  localparam int TOL_W  = 16;
  localparam int T_BITS = 18;
  localparam int T_W    = 19;

  typedef struct packed {
    logic [CODE_W-1:0] ctrl_x1;
    logic [CODE_W-1:0] ctrl_y1;
    logic [CODE_W-1:0] ctrl_x2;
    logic [CODE_W-1:0] ctrl_y2;
    logic [POS_W-1:0]  position;
  } bez_item_t;

  typedef enum logic [0:0] {
    REG_STOP_TOL = 1'b0
  } bez_reg_t;
endpackage

// ===== rtl/bez_if.sv =====
// valid/ready channel interface
// depends on nothing; payload width is a parameter
interface bez_if #(parameter int W = 8) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/bezier_easing_bisection_core.sv =====
// top level: cubic bezier easing by bisection
// uses bez_pkg, bez_if, bez_front, bez_engine
// in channel: one item = four 7-bit control codes and a 17-bit position
// out channel: one item = 17-bit eased value, Q1.16 truncated
// cfg port: APB-style, register 0 = stop tolerance (reset 7)
// items enter a two-entry queue; the engine takes one item at a time
// each curve evaluation passes through five arithmetic stages and a check
// an item needs n evaluations, n between 2 and MAX_STEPS+1 (x checks plus one y)
// the result is offered from the output state once the final y evaluation is checked
// the engine takes a new item only once the last result has been taken at the output
// reset clears queue and sequencer; tolerance returns to 7
// a stalled receiver holds the result; the queue keeps filling meanwhile
module bezier_easing_bisection_core import bez_pkg::*; #(
  parameter int MAX_STEPS = 15
) (
  input  logic        clk,
  input  logic        rst_n,
  bez_if.sink         in_ch,
  bez_if.source       out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  logic [TOL_W-1:0] tol_r;
  logic q_valid, q_pop;
  bez_item_t q_item;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[1:0] == 2'd0) ? {16'd0, tol_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) tol_r <= TOL_W'(7);
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0)
      tol_r <= cfg_pwdata[TOL_W-1:0];
  end

  bez_front u_front (
    .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_item(in_ch.data), .q_valid, .q_pop, .q_item
  );

  bez_engine #(.MAX_STEPS(MAX_STEPS)) u_engine (
    .clk, .rst_n, .tol(tol_r), .q_valid, .q_pop, .q_item,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_value(out_ch.data)
  );
endmodule

// ===== rtl/bez_front.sv =====
// front end: two-entry item queue between input and bisection engine
// uses bez_pkg
module bez_front import bez_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  bez_item_t in_item,
  output logic      q_valid,
  input  logic      q_pop,
  output bez_item_t q_item
);
  bez_item_t  mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_item;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

// ===== rtl/bez_engine.sv =====
// back end: bisection sequencer around a multi-cycle curve evaluation
// uses bez_pkg
module bez_engine import bez_pkg::*; #(
  parameter int MAX_STEPS = 15
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [TOL_W-1:0] tol,
  input  logic             q_valid,
  output logic             q_pop,
  input  bez_item_t        q_item,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [POS_W-1:0] out_value
);
  localparam int SH = 3*T_BITS - FRAC_BITS;
  localparam int I_W = $clog2(MAX_STEPS+1);
  localparam int X_W = 61 - SH;
  localparam int RECIP_SH = 30;
  localparam logic [23:0] RECIP = 24'd8454661;  // ceil(2^30 / 127)

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001, S_M1 = 8'b00000010, S_M2 = 8'b00000100,
    S_M3   = 8'b00001000, S_M4 = 8'b00010000, S_M5 = 8'b00100000,
    S_CHK  = 8'b01000000, S_OUT = 8'b10000000
  } st_t;

  st_t st_r, st_nxt;
  bez_item_t it_r;
  logic [T_W-1:0] t_r;
  logic [I_W-1:0] i_r;
  logic final_r;
  logic [27:0] b_r;             // 3*s*c1 + 3*t*c2
  logic [37:0] c_r;             // t*t
  logic [47:0] w_r;             // s*b + 127*t*t
  logic [42:0] plo_r, phi_r;    // t times low and high halves of w
  logic [63:0] n_r;
  logic [POS_W-1:0] q_r;
  logic [POS_W-1:0] res_r;

  logic [T_W-1:0] s;
  logic [CODE_W-1:0] c1, c2;
  logic [X_W-1:0] x;
  logic [X_W+23:0] prod;
  logic signed [POS_W+1:0] err;
  logic [POS_W+1:0] mag;
  logic [T_W-1:0] stp;

  assign s  = T_W'(1 << T_BITS) - t_r;
  assign c1 = final_r ? it_r.ctrl_y1 : it_r.ctrl_x1;
  assign c2 = final_r ? it_r.ctrl_y2 : it_r.ctrl_x2;
  // n = t*(s*(3*s*c1 + 3*t*c2) + 127*t^2); floor(n/127) >> SH taken as
  // floor((n >> SH) / 127) by reciprocal multiply, exact for x below 2^23
  assign x    = X_W'(n_r >> SH);
  assign prod = (X_W+24)'(x) * (X_W+24)'(RECIP);
  assign err  = $signed({2'b0, q_r}) - $signed({2'b0, it_r.position});
  assign mag  = err[POS_W+1] ? (POS_W+2)'(-err) : (POS_W+2)'(err);
  assign stp  = T_W'(1) << (T_BITS - 2 - int'(i_r));
  assign q_pop = (st_r == S_IDLE) && q_valid;
  assign out_valid = (st_r == S_OUT);
  assign out_value = res_r;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (q_valid) st_nxt = S_M1;
      S_M1:   st_nxt = S_M2;
      S_M2:   st_nxt = S_M3;
      S_M3:   st_nxt = S_M4;
      S_M4:   st_nxt = S_M5;
      S_M5:   st_nxt = S_CHK;
      S_CHK:  st_nxt = (final_r) ? S_OUT : S_M1;
      S_OUT:  if (out_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: if (q_valid) begin
        it_r <= q_item; t_r <= T_W'(1 << (T_BITS-1)); i_r <= '0; final_r <= 1'b0;
      end
      S_M1: begin
        b_r <= 28'(c1) * 28'd3 * 28'(s) + 28'(c2) * 28'd3 * 28'(t_r);
        c_r <= 38'(t_r) * 38'(t_r);
      end
      S_M2: w_r <= 48'(s) * 48'(b_r) + 48'(c_r) * 48'd127;
      S_M3: begin
        plo_r <= 43'(t_r) * 43'(w_r[23:0]);
        phi_r <= 43'(t_r) * 43'(w_r[47:24]);
      end
      S_M4: n_r <= (64'(phi_r) << 24) + 64'(plo_r);
      S_M5: q_r <= prod[RECIP_SH +: POS_W];
      S_CHK: begin
        if (final_r) res_r <= q_r;
        else if (err == 0 || mag < (POS_W+2)'(tol) || int'(i_r) >= MAX_STEPS - 1 + 1)
          final_r <= 1'b1;
        else begin
          if (!err[POS_W+1]) t_r <= t_r - stp; else t_r <= t_r + stp;
          i_r <= i_r + 1'b1;
          if (int'(i_r) == MAX_STEPS - 1) final_r <= 1'b1;
        end
      end
      default: ;
    endcase
    if (!rst_n) st_r <= S_IDLE; else st_r <= st_nxt;
  end
endmodule

// ===== rtl/bez_checker.sv =====
// port-level checker for the easing core, bound to the top level
// uses only top-level port signals
module bez_checker (
  input logic clk, rst_n, in_valid, in_ready, out_valid, out_ready,
  input logic [16:0] out_data
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out held");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data <= 17'd65536) else $error("out range");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid) else $error("reset");
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid) else $error("in held");
endmodule
bind bezier_easing_bisection_core bez_checker u_chk (
  .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);

// ===== test/tb_if.sv =====
// testbench side of the channels: none needed beyond rtl bez_if
// depends on rtl/bez_pkg.sv
package tb_bez_pkg;
  import bez_pkg::*;
  localparam int RES_W = 17;
endpackage

// ===== test/tb.sv =====
// testbench for bezier_easing_bisection_core: random and directed items,
// a bit-exact bisection predictor, and a scoreboard on the result channel
// depends on bez_pkg, bez_if, tb_bez_pkg and the core rtl
module tb;
  import bez_pkg::*;
  import tb_bez_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEPS   = 15;
  localparam int FRAC    = 16;
  localparam int LIMIT   = 400000;
  localparam int IN_W    = $bits(bez_item_t);

  logic clk, rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [1:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic cfg_pready;

  bez_if #(.W(IN_W))  in_ch ();
  bez_if #(.W(RES_W)) out_ch ();

  bezier_easing_bisection_core #(.MAX_STEPS(STEPS)) u_top (
    .clk, .rst_n, .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  // predictor's copy of the tolerance register
  logic [TOL_W-1:0] tol_shadow;

  bez_item_t      pending_items[$];
  logic [RES_W-1:0] expected_ease[$];
  int  errors = 0, cycles = 0, sent = 0, received = 0;
  logic feeding;
  int  burst_left, gap_left;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // exact curve value: n / (127 * 2^54), truncated to q1.16
  function automatic logic [63:0] curve_q16(logic [18:0] t, logic [6:0] c1, logic [6:0] c2);
    logic [63:0] s, n;
    s = 64'd262144 - t;
    n = 64'd3 * s * s * t * c1 + 64'd3 * s * t * t * c2 + 64'd127 * t * t * t;
    return (n / 64'd127) >> (3 * T_BITS - FRAC);
  endfunction

  function automatic logic [RES_W-1:0] ease_predict(bez_item_t it);
    logic [18:0] t;
    longint err, mag;
    t = 19'd131072;
    for (int i = 0; i < STEPS; i++) begin
      err = longint'(curve_q16(t, it.ctrl_x1, it.ctrl_x2)) - longint'(it.position);
      mag = (err < 0) ? -err : err;
      if (err == 0 || mag < longint'(tol_shadow)) break;
      if (i + 2 <= T_BITS) begin
        if (err > 0) t = t - (19'd1 << (T_BITS - 2 - i));
        else t = t + (19'd1 << (T_BITS - 2 - i));
      end
    end
    return RES_W'(curve_q16(t, it.ctrl_y1, it.ctrl_y2));
  endfunction

  // sender: bursts of random length with random gaps; predicts at acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_ease.push_back(ease_predict(bez_item_t'(in_ch.data)));
        sent <= sent + 1;
      end
      if (in_ch.valid && !in_ch.ready) begin
        // hold the item until it is taken
      end else if (feeding && pending_items.size() > 0 && gap_left == 0) begin
        in_ch.valid <= 1'b1;
        in_ch.data <= pending_items.pop_front();
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_ch.valid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end
    end
  end

  // receiver stalls on its own pattern: long free runs and stall bursts
  int stall_phase;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (stall_phase[9]) out_ch.ready <= 1'b1;
      else out_ch.ready <= ($urandom_range(0, 3) != 0) || stall_phase[5];
      if (out_ch.valid && out_ch.ready) begin
        received <= received + 1;
        if (expected_ease.size() == 0) begin
          $error("eased_value: no result expected, actual %0d", out_ch.data);
          errors <= errors + 1;
        end else begin
          logic [RES_W-1:0] want;
          want = expected_ease.pop_front();
          if (want !== out_ch.data) begin
            $error("eased_value: expected %0d actual %0d", want, out_ch.data);
            errors <= errors + 1;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic cfg_write(logic [TOL_W-1:0] tol);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= 2'({REG_STOP_TOL, 2'b00}); // register 0 at byte 0
    cfg_pwdata <= 32'(tol);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    tol_shadow = tol;
  endtask

  // push items and let them drain; then a pause for any in-flight work
  task automatic run_phase();
    feeding = 1'b1;
    while (pending_items.size() != 0) @(posedge clk);
    @(posedge clk);
    while (in_ch.valid) @(posedge clk);
    feeding = 1'b0;
    while (expected_ease.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic bez_item_t rand_item();
    bez_item_t it;
    it.ctrl_x1 = 7'($urandom_range(0, 127));
    it.ctrl_y1 = 7'($urandom_range(0, 127));
    it.ctrl_x2 = 7'($urandom_range(0, 127));
    it.ctrl_y2 = 7'($urandom_range(0, 127));
    case ($urandom_range(0, 9))
      0: it.position = 17'($urandom_range(65537, 131071)); // beyond one
      1: it.position = $urandom_range(0, 1) ? 17'd0 : 17'd65536;
      default: it.position = 17'($urandom_range(0, 65536));
    endcase
    return it;
  endfunction

  task automatic add_item(logic [6:0] x1, logic [6:0] y1, logic [6:0] x2, logic [6:0] y2,
                          logic [16:0] pos);
    bez_item_t it;
    it = '{x1, y1, x2, y2, pos};
    pending_items.push_back(it);
  endtask

  initial begin
    logic [TOL_W-1:0] tols[5];
    rst_n = 1'b0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    feeding = 1'b0;
    tol_shadow = 16'd7;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, position beyond one, linear and steep curves
    add_item(7'd0, 7'd0, 7'd0, 7'd0, 17'd0);
    add_item(7'd127, 7'd127, 7'd127, 7'd127, 17'd65536);
    add_item(7'd0, 7'd127, 7'd127, 7'd0, 17'd32768);
    add_item(7'd127, 7'd0, 7'd0, 7'd127, 17'd32768);
    add_item(7'd42, 7'd42, 7'd85, 7'd85, 17'd12345);
    add_item(7'd127, 7'd127, 7'd0, 7'd0, 17'd131071);
    add_item(7'd85, 7'd42, 7'd42, 7'd85, 17'd65537);
    add_item(7'd1, 7'd126, 7'd126, 7'd1, 17'd1);
    add_item(7'd64, 7'd10, 7'd64, 7'd100, 17'd65535);
    add_item(7'd127, 7'd0, 7'd127, 7'd0, 17'd21845);
    run_phase();

    // zero tolerance (only exact hits end the search early), max tolerance, and mid values
    tols = '{16'd0, 16'd65535, 16'd1, 16'd7, 16'($urandom_range(2, 4000))};
    foreach (tols[k]) begin
      cfg_write(tols[k]);
      add_item(7'd0, 7'd127, 7'd127, 7'd0, 17'd40000);
      add_item(7'd42, 7'd42, 7'd85, 7'd85, 17'd0);
      for (int n = 0; n < 100; n++) pending_items.push_back(rand_item());
      run_phase();
    end

    $display("covered %0d items over %0d tolerance settings, incl. zero and full scale",
             received, 6);
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/bez_pkg.sv
rtl/bez_if.sv
rtl/bez_front.sv
rtl/bez_engine.sv
rtl/bezier_easing_bisection_core.sv
rtl/bez_checker.sv
test/tb_if.sv
test/tb.sv
